/* rtl/core/tirp_pkg.sv */
// ----------------------------------------------------------------------------
// tirp_pkg
// Shared types, register indexes and defaults of the tilted row projection.
// ----------------------------------------------------------------------------
package tirp_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 16;

	localparam int SIZE_W     = 11;
	localparam int SLOPE_W    = 18;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_DATA_W = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int SAMPLE_W   = 16;
	localparam int READ_BIN_W = 10;
	localparam int SUM_W      = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_SLOPE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_ENABLE  = 2'd3;

	// request codes
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

	typedef struct packed {
		logic [SIZE_W-1:0]         frame_width;
		logic [SIZE_W-1:0]         frame_height;
		logic signed [SLOPE_W-1:0] tilt_slope;
		logic                      dark_subtract_enable;
	} cfg_t;

endpackage

/* rtl/core/tilted_image_row_projection.sv */
// ----------------------------------------------------------------------------
// tilted_image_row_projection
// Accumulates pixels, dark-corrected when enabled, into tilted row bins; a read returns a bin and clears it.
// ----------------------------------------------------------------------------
// read path: a read word passes stage one, then the output register behind bin_sum
// throughput: one word per cycle unless a read word in stage one waits on a
// full output register; bins are read at accept and written back from stage
// one, with the last write forwarded to the next word
// reset: a clearing pass zeroes all MAX_HEIGHT bin entries, one entry per cycle;
// in_ready stays low meanwhile, config writes still land
module tilted_image_row_projection
	import tirp_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    req_type,
	input  logic [SAMPLE_W-1:0]     pixel_value,
	input  logic [SAMPLE_W-1:0]     dark_value,
	input  logic [READ_BIN_W-1:0]   read_bin,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SUM_W-1:0] bin_sum
);

	localparam int AW  = $clog2(MAX_HEIGHT);
	localparam int RBW = ((READ_BIN_W > AW) ? READ_BIN_W : AW) + 1;

	cfg_t cfg_q;

	logic          accept;
	logic [AW-1:0] pix_addr;
	logic          pix_hit;
	logic [RBW-1:0] rd_ext;
	logic [AW-1:0] rd_addr;
	logic          rd_hit;
	logic [SUM_W-1:0] pix_ext;
	logic [SUM_W-1:0] dark_ext;
	logic [SUM_W-1:0] add_val;

	logic             valid_s1;
	logic             read_s1;
	logic             hit_s1;
	logic [AW-1:0]    addr_s1;
	logic [SUM_W-1:0] add_s1;
	logic [SUM_W-1:0] mem_rd_s1;
	logic             go_s1;

	logic             fwd_valid_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [SUM_W-1:0] fwd_data_q;
	logic [SUM_W-1:0] old_val;
	logic [SUM_W-1:0] new_val;

	logic             clr_active_q;
	logic [AW-1:0]    clr_addr_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [SUM_W-1:0] mem_wdata;
	logic [SUM_W-1:0] acc_mem [MAX_HEIGHT];

	logic             out_valid_q;
	logic [SUM_W-1:0] bin_sum_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width          <= FRAME_WIDTH_RST;
			cfg_q.frame_height         <= FRAME_HEIGHT_RST;
			cfg_q.tilt_slope           <= '0;
			cfg_q.dark_subtract_enable <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width          <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height         <= cfg_data[SIZE_W-1:0];
				REG_TILT_SLOPE:   cfg_q.tilt_slope           <= cfg_data[SLOPE_W-1:0];
				REG_DARK_ENABLE:  cfg_q.dark_subtract_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign go_s1    = valid_s1 && (!read_s1 || !out_valid_q || out_ready);
	assign in_ready = !clr_active_q && (!valid_s1 || go_s1);
	assign accept   = in_valid && in_ready;

	tirp_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.step     (accept && req_type == REQ_PIXEL),
		.bin_addr (pix_addr),
		.bin_hit  (pix_hit)
	);

	assign rd_ext  = RBW'(read_bin);
	assign rd_addr = rd_ext[AW-1:0];
	assign rd_hit  = rd_ext < RBW'(MAX_HEIGHT);

	assign pix_ext  = SUM_W'(pixel_value[PIXEL_BITS-1:0]);
	assign dark_ext = SUM_W'(dark_value[PIXEL_BITS-1:0]);
	assign add_val  = cfg_q.dark_subtract_enable ? pix_ext - dark_ext : pix_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1 <= (req_type == REQ_READ);
			hit_s1  <= (req_type == REQ_READ) ? rd_hit : pix_hit;
			addr_s1 <= (req_type == REQ_READ) ? rd_addr : pix_addr;
			add_s1  <= add_val;
		end
	end

	// bin memory, read at accept, written back from stage one
	always_ff @(posedge clk) begin
		if (mem_we)
			acc_mem[mem_waddr] <= mem_wdata;
		if (accept)
			mem_rd_s1 <= acc_mem[(req_type == REQ_READ) ? rd_addr : pix_addr];
	end

	// the word just ahead may have written the same bin at our read edge
	assign old_val = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : mem_rd_s1;
	assign new_val = read_s1 ? '0 : old_val + add_s1;

	assign mem_we    = clr_active_q || (go_s1 && hit_s1);
	assign mem_waddr = clr_active_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clr_active_q ? '0 : new_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (go_s1 && hit_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && hit_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(MAX_HEIGHT - 1))
				clr_active_q <= 1'b0;
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && read_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && read_s1)
			bin_sum_q <= hit_s1 ? old_val : '0;
	end

	assign out_valid = out_valid_q;
	assign bin_sum   = bin_sum_q;

	a_clr_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !in_ready && !valid_s1)
		else $error("word taken during clearing pass");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word lost before stage one");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go_s1 |=> valid_s1 && $stable(addr_s1) && $stable(read_s1))
		else $error("stalled stage one changed");

	a_full_out_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && read_s1 && out_valid_q && !out_ready |-> !in_ready && !mem_we)
		else $error("read word passed a full output register");

endmodule

/* rtl/core/tirp_raster.sv */
// ----------------------------------------------------------------------------
// tirp_raster
// Raster position tracking and tilted bin index for the current pixel.
// ----------------------------------------------------------------------------
module tirp_raster
	import tirp_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          step,
	output logic [RW-1:0] bin_addr,
	output logic          bin_hit
);

	localparam int TW  = CW + SLOPE_W;
	localparam int CLW = TW - FRAC_BITS + 1;
	localparam int WW  = (SIZE_W > CW + 1) ? SIZE_W : CW + 1;
	localparam int HW  = (SIZE_W > RW + 1) ? SIZE_W : RW + 1;
	localparam int BW  = ((CLW > RW + 1) ? CLW : RW + 1) + 1;

	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic signed [TW-1:0] tilt_q;

	logic [WW-1:0]  w_eff;
	logic [HW-1:0]  h_eff;
	logic [TW:0]    tilt_rnd;
	logic [CLW-1:0] tilt_ceil;
	logic [BW-1:0]  bin;
	logic           last_col;
	logic           last_row;

	// zero counts as one, oversize as the maximum
	always_comb begin
		if (cfg.frame_width == '0)
			w_eff = WW'(1);
		else if (WW'(cfg.frame_width) > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(cfg.frame_width);
		if (cfg.frame_height == '0)
			h_eff = HW'(1);
		else if (HW'(cfg.frame_height) > HW'(MAX_HEIGHT))
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(cfg.frame_height);
	end

	// ceil of the q16 running sum: add the fraction mask, keep the integer part
	assign tilt_rnd  = {tilt_q[TW-1], tilt_q} + (TW+1)'((1 << FRAC_BITS) - 1);
	assign tilt_ceil = tilt_rnd[TW:FRAC_BITS];
	assign bin = {{(BW-RW){1'b0}}, row_q} + {{(BW-CLW){tilt_ceil[CLW-1]}}, tilt_ceil};

	assign bin_hit  = !bin[BW-1] && (bin[BW-2:0] < (BW-1)'(h_eff[RW:0]));
	assign bin_addr = bin[RW-1:0];

	assign last_col = (WW'(col_q) + WW'(1)) >= w_eff;
	assign last_row = (HW'(row_q) + HW'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			tilt_q <= '0;
		end else if (step) begin
			if (last_col) begin
				col_q  <= '0;
				tilt_q <= '0;
				row_q  <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q  <= col_q + CW'(1);
				tilt_q <= tilt_q + {{(TW-SLOPE_W){cfg.tilt_slope[SLOPE_W-1]}}, cfg.tilt_slope};
			end
		end
	end

endmodule
